FILE: hw/rtl/tvnm_pkg.sv
package tvnm_pkg;

    // fixed field widths
    localparam int VEC_W     = 48;
    localparam int DIST_W    = 6;
    localparam int IDX_OUT_W = 6;
    localparam int CNT_OUT_W = 7;

    // function codes
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_SEARCH = 2'd1;
    localparam logic [1:0] FUNC_BOTH   = 2'd2;

    // input beat
    typedef struct packed {
        logic [1:0]       func;
        logic [VEC_W-1:0] vec_nonzero;
        logic [VEC_W-1:0] vec_negative;
    } t_in;

    // result beat
    typedef struct packed {
        logic                 found;
        logic [IDX_OUT_W-1:0] match_index;
        logic [DIST_W-1:0]    match_distance;
        logic [VEC_W-1:0]     match_nonzero;
        logic [VEC_W-1:0]     match_negative;
        logic [CNT_OUT_W-1:0] stored_count;
    } t_out;

    // query and running best handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              search;
        logic [VEC_W-1:0]  q_nz;
        logic [VEC_W-1:0]  q_ng;
        logic [DIST_W-1:0] best_cost;
        logic [VEC_W-1:0]  best_nz;
        logic [VEC_W-1:0]  best_ng;
    } t_link;

endpackage

FILE: hw/rtl/tvnm_cell.sv
module tvnm_cell #(
    parameter int CELL_INDEX = 0,
    parameter int IDX_W      = 6,
    parameter int CNT_W      = 7,
    parameter int VECTOR_LEN = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tvnm_pkg::t_link               i_link,
    input  logic [IDX_W-1:0]              i_best_idx,
    input  logic [CNT_W-1:0]              i_count,
    input  logic                          i_wr_en,
    input  logic [tvnm_pkg::VEC_W-1:0]    i_wr_nz,
    input  logic [tvnm_pkg::VEC_W-1:0]    i_wr_ng,
    output tvnm_pkg::t_link               o_link,
    output logic [IDX_W-1:0]              o_best_idx
);
    import tvnm_pkg::*;

    localparam logic [VEC_W-1:0] VEC_MASK = {VEC_W{1'b1}} >> (VEC_W - VECTOR_LEN);

    logic [VEC_W-1:0]  r_slot_nz;
    logic [VEC_W-1:0]  r_slot_ng;
    t_link             r_link;
    t_link             n_link;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic              w_active;
    logic [VEC_W-1:0]  w_diff;
    logic [DIST_W-1:0] w_dist;

    // stored slot, written only by an insert
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_slot_nz <= i_wr_nz;
            r_slot_ng <= i_wr_ng;
        end
    end

    // distance of the passing query to this slot
    assign w_active = i_link.search && (CNT_W'(CELL_INDEX) < i_count);
    assign w_diff   = ((i_link.q_nz ^ r_slot_nz) | (i_link.q_ng ^ r_slot_ng)) & VEC_MASK;
    assign w_dist   = DIST_W'($countones(w_diff));

    // keep the running best, strict compare so the lower slot wins a tie
    always_comb begin
        n_link = i_link;
        n_idx  = i_best_idx;
        if (w_active && (w_dist < i_link.best_cost)) begin
            n_link.best_cost = w_dist;
            n_link.best_nz   = r_slot_nz;
            n_link.best_ng   = r_slot_ng;
            n_idx            = IDX_W'(CELL_INDEX);
        end
    end

    // hand on to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
        r_idx <= n_idx;
    end

    assign o_link     = r_link;
    assign o_best_idx = r_idx;

endmodule

FILE: hw/rtl/ternary_vector_nearest_match_store.sv
// Nearest-match store for ternary vectors kept as nonzero and negative masks.
// Input: a beat is taken at a rising edge with start high and busy low. func
// selects insert, search, or search followed by insert of the same vector; code 3 does neither.
// Result: one beat per input, on o_result for one cycle with o_strobe high;
// the receiver cannot stall it and must take it in that cycle.
// Every item runs the query once down a row of STORE_DEPTH cells, one cell
// per slot, one cell per cycle; each cell compares its slot and keeps the
// running best, the lower slot winning on equal distance.
// The query passes the capture registers and then the register of every
// cell in turn; busy falls as the strobe rises, so a new item is taken only
// once the last is through, and the pass grows with the length of the cell row.
// An insert is written at the end of the pass, so a search-then-insert sees
// the store as it was before.
// Reset clears the head, the count and the pipeline; slot contents are left
// as they are and only written slots are ever compared.
module ternary_vector_nearest_match_store #(
    parameter int STORE_DEPTH = 64,
    parameter int VECTOR_LEN  = 48
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  tvnm_pkg::t_in   i_in,
    output logic            o_strobe,
    output tvnm_pkg::t_out  o_result
);
    import tvnm_pkg::*;

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam logic [VEC_W-1:0] VEC_MASK = {VEC_W{1'b1}} >> (VEC_W - VECTOR_LEN);

    logic             r_busy;
    logic             r_launch;
    logic             r_strobe;
    logic             r_search;
    logic             r_ins;
    logic [VEC_W-1:0] r_q_nz;
    logic [VEC_W-1:0] r_q_ng;
    logic [IDX_W-1:0] r_head;
    logic [IDX_W-1:0] n_head;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_out             r_out;
    t_out             n_out;
    logic             w_accept;
    logic             w_finish;
    logic [VEC_W-1:0] w_nz;

    t_link            w_link [STORE_DEPTH+1];
    logic [IDX_W-1:0] w_idx  [STORE_DEPTH+1];

    assign w_accept = start && !r_busy;
    assign w_nz     = i_in.vec_nonzero & VEC_MASK;

    // query capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q_nz   <= w_nz;
            r_q_ng   <= i_in.vec_negative & w_nz;
            r_search <= ((i_in.func == FUNC_SEARCH) || (i_in.func == FUNC_BOTH))
                        && (r_count != '0);
            r_ins    <= (i_in.func == FUNC_INSERT) || (i_in.func == FUNC_BOTH);
        end
    end

    // head of the cell row
    always_comb begin
        w_link[0].valid     = r_launch;
        w_link[0].search    = r_search;
        w_link[0].q_nz      = r_q_nz;
        w_link[0].q_ng      = r_q_ng;
        w_link[0].best_cost = DIST_W'(VECTOR_LEN + 1);
        w_link[0].best_nz   = '0;
        w_link[0].best_ng   = '0;
        w_idx[0]            = '0;
    end

    // one cell per slot
    for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
        logic w_wr_en;
        assign w_wr_en = w_finish && r_ins && (r_head == IDX_W'(g));
        tvnm_cell #(
            .CELL_INDEX (g),
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W),
            .VECTOR_LEN (VECTOR_LEN)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_link     (w_link[g]),
            .i_best_idx (w_idx[g]),
            .i_count    (r_count),
            .i_wr_en    (w_wr_en),
            .i_wr_nz    (r_q_nz),
            .i_wr_ng    (r_q_ng),
            .o_link     (w_link[g+1]),
            .o_best_idx (w_idx[g+1])
        );
    end

    assign w_finish = w_link[STORE_DEPTH].valid;

    // head and count after the insert
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (r_ins) begin
            n_head = (r_head == IDX_W'(STORE_DEPTH - 1)) ? '0 : r_head + 1'b1;
            if (r_count != CNT_W'(STORE_DEPTH)) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    // result beat
    always_comb begin
        n_out                = '0;
        n_out.stored_count   = CNT_OUT_W'(n_count);
        if (w_link[STORE_DEPTH].search) begin
            n_out.found          = 1'b1;
            n_out.match_index    = IDX_OUT_W'(w_idx[STORE_DEPTH]);
            n_out.match_distance = w_link[STORE_DEPTH].best_cost;
            n_out.match_nonzero  = w_link[STORE_DEPTH].best_nz;
            n_out.match_negative = w_link[STORE_DEPTH].best_ng;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out <= n_out;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_launch <= 1'b0;
            r_strobe <= 1'b0;
            r_head   <= '0;
            r_count  <= '0;
        end else begin
            r_launch <= w_accept;
            r_strobe <= w_finish;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_finish) begin
                r_busy <= 1'b0;
            end
            if (w_finish) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

FILE: tb/sv/ternary_vector_nearest_match_store_test.sv
module ternary_vector_nearest_match_store_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tvnm_pkg::*;

    localparam int          DEPTH        = 64;
    localparam int          LEN          = 48;
    localparam logic [47:0] LEN_MASK     = {48{1'b1}} >> (48 - LEN);
    localparam logic [47:0] ONES         = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] ALT          = 48'h5555_5555_5555;
    localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
    localparam int          RANDOM_ITEMS = 1400;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_LIMIT  = 4 * (DEPTH + 2);

    // one line of the directed stimulus table
    typedef struct {
        t_in  beat;
        bit   typed;
        t_out result;
    } t_row;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in  beat_in = '0;
    logic o_strobe;
    t_out o_result;

    // expectation typed into the table travels with the beat
    bit   row_typed = 1'b0;
    t_out row_result = '0;

    // shadow of the store
    logic [47:0] store_nz [DEPTH];
    logic [47:0] store_ng [DEPTH];
    int          store_head = 0;
    int          store_count = 0;

    t_out pending_matches [$];
    int   error_count = 0;

    ternary_vector_nearest_match_store dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_in     (beat_in),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    // search then insert on the shadow store, result of one beat
    function automatic t_out search_and_store(input t_in beat);
        logic [47:0] qnz;
        logic [47:0] qng;
        logic [47:0] diff;
        int          best;
        int          best_cost;
        int          d;
        t_out        res;
        qnz = beat.vec_nonzero & LEN_MASK;
        qng = beat.vec_negative & qnz;
        res = '0;
        if ((beat.func == FUNC_SEARCH || beat.func == FUNC_BOTH) && store_count != 0) begin
            best = 0;
            best_cost = LEN + 1;
            for (int i = 0; i < store_count; i++) begin
                diff = (qnz ^ store_nz[i]) | (qng ^ store_ng[i]);
                d = $countones(diff & LEN_MASK);
                if (d < best_cost) begin
                    best_cost = d;
                    best = i;
                end
            end
            res.found          = 1'b1;
            res.match_index    = 6'(best);
            res.match_distance = 6'(best_cost);
            res.match_nonzero  = store_nz[best];
            res.match_negative = store_ng[best];
        end
        if (beat.func == FUNC_INSERT || beat.func == FUNC_BOTH) begin
            store_nz[store_head] = qnz;
            store_ng[store_head] = qng;
            store_head = (store_head + 1) % DEPTH;
            if (store_count < DEPTH) store_count++;
        end
        res.stored_count = 7'(store_count);
        return res;
    endfunction

    // check result beats, then log accepted input beats
    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        if (o_strobe === 1'b1) begin
            got = o_result;
            if (pending_matches.size() == 0) begin
                $error("result beat with no item outstanding");
                error_count++;
            end else begin
                want = pending_matches.pop_front();
                if (got.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, got.found);
                    error_count++;
                end
                if (got.match_index !== want.match_index) begin
                    $error("match_index: expected %0d, got %0d",
                           want.match_index, got.match_index);
                    error_count++;
                end
                if (got.match_distance !== want.match_distance) begin
                    $error("match_distance: expected %0d, got %0d",
                           want.match_distance, got.match_distance);
                    error_count++;
                end
                if (got.match_nonzero !== want.match_nonzero) begin
                    $error("match_nonzero: expected %h, got %h",
                           want.match_nonzero, got.match_nonzero);
                    error_count++;
                end
                if (got.match_negative !== want.match_negative) begin
                    $error("match_negative: expected %h, got %h",
                           want.match_negative, got.match_negative);
                    error_count++;
                end
                if (got.stored_count !== want.stored_count) begin
                    $error("stored_count: expected %0d, got %0d",
                           want.stored_count, got.stored_count);
                    error_count++;
                end
            end
        end
        if (i_rst_n && start && busy === 1'b0) begin
            want = search_and_store(beat_in);
            pending_matches.push_back(row_typed ? row_result : want);
        end
    end

    // watchdog on cycles with no beat in either direction
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && busy === 1'b0) || o_strobe === 1'b1)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // present one beat after an idle gap and hold it until taken
    task automatic drive_item(input t_in item, input bit typed, input t_out result,
                              input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        beat_in    <= item;
        row_typed  <= typed;
        row_result <= result;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    function automatic t_row make_row(input logic [1:0] func, input logic [47:0] nz,
                                      input logic [47:0] ng, input bit typed,
                                      input logic found, input int idx, input int mdist,
                                      input logic [47:0] mnz, input logic [47:0] mng,
                                      input int cnt);
        t_row r;
        r.beat.func                = func;
        r.beat.vec_nonzero         = nz;
        r.beat.vec_negative        = ng;
        r.typed                    = typed;
        r.result.found             = found;
        r.result.match_index       = 6'(idx);
        r.result.match_distance    = 6'(mdist);
        r.result.match_nonzero     = mnz;
        r.result.match_negative    = mng;
        r.result.stored_count      = 7'(cnt);
        return r;
    endfunction

    initial begin
        t_row        directed_rows [$];
        t_in         recent_vectors [$];
        t_in         item;
        t_in         base;
        t_out        no_result;
        logic [47:0] nz;
        logic [47:0] ng;
        int          gap;
        int          pick;
        int          bit_pos;
        int          drain_cycles;
        bit          burst;

        no_result = '0;

        // reset
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: empty store, masking, extremes, ties, unused code
        directed_rows.push_back(make_row(FUNC_SEARCH, ONES, ONES, 1, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_UNUSED, ONES, ONES, 1, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_BOTH, ONES, ONES, 1, 0, 0, 0, 0, 0, 1));
        directed_rows.push_back(make_row(FUNC_SEARCH, ONES, ONES, 1, 1, 0, 0, ONES, ONES, 1));
        directed_rows.push_back(make_row(FUNC_SEARCH, 0, 0, 1, 1, 0, 48, ONES, ONES, 1));
        // negative bits without nonzero bits are dropped
        directed_rows.push_back(make_row(FUNC_INSERT, 0, ONES, 1, 0, 0, 0, 0, 0, 2));
        directed_rows.push_back(make_row(FUNC_SEARCH, 0, ONES, 1, 1, 1, 0, 0, 0, 2));
        directed_rows.push_back(make_row(FUNC_INSERT, ONES, 0, 1, 0, 0, 0, 0, 0, 3));
        directed_rows.push_back(make_row(FUNC_SEARCH, ONES, 0, 1, 1, 2, 0, ONES, 0, 3));
        // duplicate of slot 0, lowest slot wins the tie
        directed_rows.push_back(make_row(FUNC_INSERT, ONES, ONES, 1, 0, 0, 0, 0, 0, 4));
        directed_rows.push_back(make_row(FUNC_SEARCH, ONES, ONES, 1, 1, 0, 0, ONES, ONES, 4));
        directed_rows.push_back(make_row(FUNC_BOTH, ALT, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_SEARCH, ALT, ALT, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_UNUSED, 0, 0, 1, 0, 0, 0, 0, 0, 5));
        directed_rows.push_back(make_row(FUNC_SEARCH, 48'h8000_0000_0000,
                                         48'h8000_0000_0000, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_INSERT, 48'h1, 48'h1, 1, 0, 0, 0, 0, 0, 6));
        directed_rows.push_back(make_row(FUNC_BOTH, 48'h1, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_SEARCH, ~ALT, ALT, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_BOTH, ~ALT, ONES, 0, 0, 0, 0, 0, 0, 0));

        foreach (directed_rows[i]) begin
            if (directed_rows[i].beat.func == FUNC_INSERT ||
                directed_rows[i].beat.func == FUNC_BOTH)
                recent_vectors.push_back(directed_rows[i].beat);
            drive_item(directed_rows[i].beat, directed_rows[i].typed,
                       directed_rows[i].result, $urandom_range(0, 6));
        end

        // random part: about half the vectors close to stored vectors
        burst = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick <= 4 && recent_vectors.size() != 0) begin
                base = recent_vectors[$urandom_range(0, recent_vectors.size() - 1)];
                nz = base.vec_nonzero;
                ng = base.vec_negative & base.vec_nonzero;
                if (pick != 0) begin
                    repeat ($urandom_range(1, 6)) begin
                        bit_pos = $urandom_range(0, LEN - 1);
                        if ($urandom_range(0, 1)) nz[bit_pos] = ~nz[bit_pos];
                        else ng[bit_pos] = ~ng[bit_pos];
                    end
                end
                // junk in ignored negative bits
                if ($urandom_range(0, 2) == 0) ng = ng | (rand48() & ~nz);
            end else if (pick == 5) begin
                nz = rand48() & rand48() & rand48();
                ng = rand48();
            end else if (pick == 6) begin
                nz = $urandom_range(0, 1) ? ONES : 48'h0;
                ng = $urandom_range(0, 1) ? ONES : rand48();
            end else begin
                nz = rand48();
                ng = rand48();
            end

            pick = $urandom_range(0, 19);
            if (pick < 6)       item.func = FUNC_INSERT;
            else if (pick < 12) item.func = FUNC_SEARCH;
            else if (pick < 19) item.func = FUNC_BOTH;
            else                item.func = FUNC_UNUSED;
            item.vec_nonzero  = nz;
            item.vec_negative = ng;

            if (item.func == FUNC_INSERT || item.func == FUNC_BOTH) begin
                recent_vectors.push_back(item);
                if (recent_vectors.size() > DEPTH) void'(recent_vectors.pop_front());
            end

            gap = burst ? 0 : $urandom_range(0, 6);
            drive_item(item, 1'b0, no_result, gap);
        end
        start <= 1'b0;

        // drain outstanding results, then let the pipeline settle
        drain_cycles = 0;
        while (pending_matches.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        if (pending_matches.size() != 0) begin
            $error("%0d expected results never arrived", pending_matches.size());
            error_count++;
        end
        repeat (DEPTH + 4) @(posedge i_clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
